// ===== hdl/cvsa_pkg.sv =====
// ----------------------------------------------------------------------------
// cvsa_pkg: shared constants and types for the sweep sample accumulator
// Field widths, arithmetic widths, register indexes and the divider
// control structs used by the top level and the divider.
// ----------------------------------------------------------------------------
package cvsa_pkg;

   // Field widths
   localparam int CURRENT_BITS   = 24;
   localparam int INDEX_BITS     = 16;
   localparam int SAMPLE_INDEX_W = 16;
   localparam int MV_W           = 13;
   localparam int STEP_W         = 12;
   localparam int HALF_W         = STEP_W - 1;
   localparam int DIFF_W         = MV_W + 1;
   localparam int FRAC_BITS      = 16;
   localparam int VOLT_W         = MV_W + FRAC_BITS;
   localparam int RES_W          = 32;
   localparam int SUM_W          = 64;

   // Shared multiplier
   localparam int MUL_W          = 32;
   localparam int PROD_W         = 2 * MUL_W;

   // Voltage interpolation: |diff| * k, then scaled by 2^FRAC_BITS
   localparam int VPROD_W        = (DIFF_W - 1) + HALF_W;
   localparam int VNUM_W         = VPROD_W + FRAC_BITS;

   // Resistance: 1e6 / 65536 = 15625 / 1024
   localparam int SCALE          = 15625;
   localparam int SCALE_W        = 14;
   localparam int SCALE_SHIFT    = 10;
   localparam int MAG_W          = SUM_W - 1;
   localparam int LO_W           = MUL_W + SCALE_W;
   localparam int HI_W           = MAG_W - MUL_W;

   // Shared divider
   localparam int DIV_NUM_W      = MAG_W + SCALE_W + 1;
   localparam int DIV_DEN_W      = SUM_W + SCALE_SHIFT + 1;
   localparam int DIV_IDX_W      = $clog2(DIV_NUM_W);
   localparam int QUO_W          = 32;

   // Configuration registers
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = MV_W;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MV   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_MV    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 2'd2;

   localparam logic [MV_W-1:0]   START_MV_RESET   = 13'd0;
   localparam logic [MV_W-1:0]   PEAK_MV_RESET    = 13'd1000;
   localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 12'd200;

   // Commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_IDX_W-1:0] msb_idx;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_status_type;

endpackage

// ===== hdl/cvsa_channels.sv =====
// ----------------------------------------------------------------------------
// cvsa channels: request and response valid/ready interfaces
// One beat moves one sample or clear command in, or one result out.
// ----------------------------------------------------------------------------
interface cvsa_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       cmd;
   logic signed [cvsa_pkg::CURRENT_BITS-1:0]   current_na;

   modport source (output valid, cmd, current_na, input ready);
   modport sink   (input valid, cmd, current_na, output ready);
endinterface

interface cvsa_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic        [cvsa_pkg::SAMPLE_INDEX_W-1:0] sample_index;
   logic signed [cvsa_pkg::VOLT_W-1:0]         voltage_q;
   logic signed [cvsa_pkg::CURRENT_BITS-1:0]   current_echo;
   logic        [cvsa_pkg::CURRENT_BITS-1:0]   peak_current_na;
   logic signed [cvsa_pkg::RES_W-1:0]          resistance_ohm;

   modport source (output valid, sample_index, voltage_q, current_echo,
                   peak_current_na, resistance_ohm, input ready);
   modport sink   (input valid, sample_index, voltage_q, current_echo,
                   peak_current_na, resistance_ohm, output ready);
endinterface

// ===== hdl/cvsa_divider.sv =====
// ----------------------------------------------------------------------------
// cvsa_divider: shared restoring divider, one quotient bit per cycle
// Walks the numerator from msb_idx down to bit 0. Keeps the low QUO_W
// quotient bits and flags any quotient bit above them.
// ----------------------------------------------------------------------------
module cvsa_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  cvsa_pkg::div_req_type             req,
   input  logic [cvsa_pkg::DIV_NUM_W-1:0]    num,
   input  logic [cvsa_pkg::DIV_DEN_W-1:0]    den,
   output cvsa_pkg::div_status_type          status,
   output logic [cvsa_pkg::QUO_W-1:0]        quo,
   output logic [cvsa_pkg::DIV_DEN_W-1:0]    rem
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [cvsa_pkg::DIV_IDX_W-1:0]     idx_ff, idx_in;
   logic [cvsa_pkg::DIV_NUM_W-1:0]     num_ff, num_in;
   logic [cvsa_pkg::DIV_DEN_W-1:0]     den_ff, den_in;
   logic [cvsa_pkg::DIV_DEN_W-1:0]     rem_ff, rem_in;
   logic [cvsa_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic                               sat_ff, sat_in;

   logic [cvsa_pkg::DIV_DEN_W:0]       trial;
   logic [cvsa_pkg::DIV_DEN_W:0]       diff;
   logic                               fits;

   always_comb begin
      trial = {rem_ff, num_ff[idx_ff]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;

      if (req.start) begin
         busy_in = 1'b1;
         idx_in  = req.msb_idx;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[cvsa_pkg::DIV_DEN_W-1:0] : trial[cvsa_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[cvsa_pkg::QUO_W-2:0], fits};
         // quotient bits above the kept field mean overflow
         sat_in = sat_ff | (fits & (idx_ff >= cvsa_pkg::DIV_IDX_W'(cvsa_pkg::QUO_W)));
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign status.done = done_ff;
   assign status.sat  = sat_ff;
   assign quo         = quo_ff;
   assign rem         = rem_ff;

endmodule

// ===== hdl/cv_sweep_sample_accumulator.sv =====
// ----------------------------------------------------------------------------
// cv_sweep_sample_accumulator: triangle-sweep voltammetry sample accumulator
// Per sample: sweep voltage, peak |current|, running sums and the
// least-squares resistance through the origin.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  valid/ready sink. A beat carries cmd and current_na. cmd clear
//            zeroes the sample index, peak and both sums and returns
//            nothing. cmd sample produces exactly one rsp beat.
//   rsp_bus  valid/ready source with sample_index, voltage_q, current_echo,
//            peak_current_na and resistance_ohm.
//   csr_*    write-only register port (start_mv, peak_mv, step_count);
//            write only while no sample is in flight.
// Work: the shared one-bit-per-cycle divider runs the sweep interpolation on
//   a 40-bit numerator and the resistance quotient on a 78-bit numerator;
//   multiply and accumulate steps go through the single 32x32 multiplier.
//   While the current-squared sum is still zero the resistance division is
//   skipped and the resistance is 0.
// Throughput: one sample at a time; req ready rises again in the same cycle
//   that the result is loaded into the output register.
// Reset: synchronous, active high; registers return to 0 / 1000 mV / 200
//   steps, sums and index clear, no rsp beat pending.
// Stall: the result sits in the output register, so the next sample can be
//   taken and worked on while rsp is stalled; it waits only if its own result
//   is done before the previous one has been taken.
// ----------------------------------------------------------------------------
module cv_sweep_sample_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   cvsa_req_if.sink                          req_bus,
   cvsa_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [cvsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cvsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_VMUL  = 4'd1;
   localparam logic [ST_W-1:0] ST_VDIV  = 4'd2;
   localparam logic [ST_W-1:0] ST_VWAIT = 4'd3;
   localparam logic [ST_W-1:0] ST_PMUL  = 4'd4;
   localparam logic [ST_W-1:0] ST_SMUL  = 4'd5;
   localparam logic [ST_W-1:0] ST_SACC  = 4'd6;
   localparam logic [ST_W-1:0] ST_RMAG  = 4'd7;
   localparam logic [ST_W-1:0] ST_MLO   = 4'd8;
   localparam logic [ST_W-1:0] ST_MHI   = 4'd9;
   localparam logic [ST_W-1:0] ST_RDIV  = 4'd10;
   localparam logic [ST_W-1:0] ST_RWAIT = 4'd11;
   localparam logic [ST_W-1:0] ST_FIN   = 4'd12;

   localparam int CB = cvsa_pkg::CURRENT_BITS;
   localparam int IB = cvsa_pkg::INDEX_BITS;
   localparam int HW = cvsa_pkg::HALF_W;
   localparam int VW = cvsa_pkg::VOLT_W;
   localparam int SW = cvsa_pkg::SUM_W;

   localparam logic [SW:0] SVC_MAX = {2'b00, {(SW-1){1'b1}}};
   localparam logic [SW:0] SVC_MIN = {2'b11, {(SW-2){1'b0}}, 1'b1};

   // ---------------- registers ----------------
   logic [ST_W-1:0]                    state_ff, state_in;
   logic [cvsa_pkg::MV_W-1:0]          start_mv_ff, start_mv_in;
   logic [cvsa_pkg::MV_W-1:0]          peak_mv_ff, peak_mv_in;
   logic [cvsa_pkg::STEP_W-1:0]        steps_ff, steps_in;
   logic [IB-1:0]                      index_ff, index_in;
   logic [CB-1:0]                      peak_ff, peak_in;
   logic [SW-1:0]                      svc_ff, svc_in;     // sum v*i, signed
   logic [SW-1:0]                      scs_ff, scs_in;     // sum i*i, unsigned

   logic [CB-1:0]                      cur_ff, cur_in;
   logic [CB-1:0]                      abs_ff, abs_in;
   logic [HW-1:0]                      k_ff, k_in;
   logic [HW-1:0]                      half_ff, half_in;
   logic                               dneg_ff, dneg_in;
   logic [cvsa_pkg::PROD_W-1:0]        mul_ff, mul_in;
   logic [VW-1:0]                      v_ff, v_in;
   logic                               pneg_ff, pneg_in;
   logic                               rneg_ff, rneg_in;
   logic [cvsa_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [cvsa_pkg::LO_W-1:0]          lo_ff, lo_in;
   logic [cvsa_pkg::RES_W-1:0]         res_ff, res_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [cvsa_pkg::SAMPLE_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [VW-1:0]                      rsp_volt_ff, rsp_volt_in;
   logic [CB-1:0]                      rsp_cur_ff, rsp_cur_in;
   logic [CB-1:0]                      rsp_peak_ff, rsp_peak_in;
   logic [cvsa_pkg::RES_W-1:0]         rsp_res_ff, rsp_res_in;

   // ---------------- combinational ----------------
   logic                               req_accept;
   logic                               rsp_free;
   logic [HW-1:0]                      half_c;
   logic [IB-1:0]                      half_ext;
   logic [IB-1:0]                      fall_d;
   logic [HW-1:0]                      k_c;
   logic [cvsa_pkg::DIFF_W-1:0]        diff_c;
   logic [cvsa_pkg::DIFF_W-1:0]        dmag_c;
   logic [cvsa_pkg::MUL_W-1:0]         op_a, op_b;
   logic [cvsa_pkg::VNUM_W-1:0]        vnum_c;
   logic [VW:0]                        vbase_c, vq_c, vsum_c;
   logic [VW-1:0]                      vabs_c;
   logic [SW:0]                        term_c, svc_sum_c;
   logic [SW:0]                        scs_sum_c;
   logic [cvsa_pkg::DIV_NUM_W-1:0]     rnum_c;
   logic                               round_c;
   logic [cvsa_pkg::QUO_W:0]           rq_c;
   logic [cvsa_pkg::RES_W-1:0]         rmag_c;

   // divider hookup
   cvsa_pkg::div_req_type              div_req;
   cvsa_pkg::div_status_type           div_status;
   logic [cvsa_pkg::DIV_NUM_W-1:0]     div_num;
   logic [cvsa_pkg::DIV_DEN_W-1:0]     div_den;
   logic [cvsa_pkg::QUO_W-1:0]         div_quo;
   logic [cvsa_pkg::DIV_DEN_W-1:0]     div_rem;

   cvsa_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quo    (div_quo),
      .rem    (div_rem)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid & req_bus.ready;
   assign rsp_free      = ~rsp_valid_ff | rsp_bus.ready;

   // position on the triangle: rising up to half, mirrored, then held at 0
   always_comb begin
      half_c = steps_ff[cvsa_pkg::STEP_W-1:1];
      if (half_c == '0) begin
         half_c = HW'(1);
      end
      half_ext = IB'(half_c);
      fall_d   = index_ff - half_ext;
      if (fall_d > half_ext) begin
         fall_d = half_ext;
      end
      if (index_ff <= half_ext) begin
         k_c = index_ff[HW-1:0];
      end else begin
         k_c = half_c - fall_d[HW-1:0];
      end
      diff_c = {peak_mv_ff[cvsa_pkg::MV_W-1], peak_mv_ff}
             - {start_mv_ff[cvsa_pkg::MV_W-1], start_mv_ff};
      dmag_c = diff_c[cvsa_pkg::DIFF_W-1] ? (cvsa_pkg::DIFF_W'(0) - diff_c) : diff_c;
   end

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_VMUL: begin
            op_a = cvsa_pkg::MUL_W'(dmag_c);
            op_b = cvsa_pkg::MUL_W'(k_ff);
         end
         ST_PMUL: begin
            op_a = cvsa_pkg::MUL_W'(vabs_c);
            op_b = cvsa_pkg::MUL_W'(abs_ff);
         end
         ST_SMUL: begin
            op_a = cvsa_pkg::MUL_W'(abs_ff);
            op_b = cvsa_pkg::MUL_W'(abs_ff);
         end
         ST_MLO: begin
            op_a = mag_ff[cvsa_pkg::MUL_W-1:0];
            op_b = cvsa_pkg::MUL_W'(cvsa_pkg::SCALE);
         end
         ST_MHI: begin
            op_a = cvsa_pkg::MUL_W'(mag_ff[cvsa_pkg::MAG_W-1:cvsa_pkg::MUL_W]);
            op_b = cvsa_pkg::MUL_W'(cvsa_pkg::SCALE);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      mul_in = op_a * op_b;
   end

   // datapath terms
   always_comb begin
      // voltage numerator: |diff|*k scaled, plus half/2 for round to nearest
      vnum_c  = {mul_ff[cvsa_pkg::VPROD_W-1:0], {cvsa_pkg::FRAC_BITS{1'b0}}}
              + cvsa_pkg::VNUM_W'(half_ff >> 1);
      vbase_c = {start_mv_ff[cvsa_pkg::MV_W-1], start_mv_ff, {cvsa_pkg::FRAC_BITS{1'b0}}};
      vq_c    = dneg_ff ? ((VW+1)'(0) - {1'b0, div_quo[VW-1:0]}) : {1'b0, div_quo[VW-1:0]};
      vsum_c  = vbase_c + vq_c;
      vabs_c  = v_ff[VW-1] ? (VW'(0) - v_ff) : v_ff;

      // signed v*i into the saturating sum
      term_c    = pneg_ff ? ((SW+1)'(0) - {1'b0, mul_ff}) : {1'b0, mul_ff};
      svc_sum_c = {svc_ff[SW-1], svc_ff} + term_c;
      scs_sum_c = {1'b0, scs_ff} + {1'b0, mul_ff};

      // resistance numerator: |sum v*i| * 15625 from two partial products
      rnum_c = {mul_ff[cvsa_pkg::LO_W-1:0], {cvsa_pkg::MUL_W{1'b0}}}
             + cvsa_pkg::DIV_NUM_W'(lo_ff);

      round_c = ({div_rem, 1'b0} >= {1'b0, div_den});
      rq_c    = {1'b0, div_quo} + (cvsa_pkg::QUO_W+1)'(round_c);
      if (div_status.sat || (rq_c[cvsa_pkg::QUO_W:cvsa_pkg::RES_W-1] != '0)) begin
         rmag_c = {1'b0, {(cvsa_pkg::RES_W-1){1'b1}}};
      end else begin
         rmag_c = {1'b0, rq_c[cvsa_pkg::RES_W-2:0]};
      end
   end

   // divider request: voltage interpolation or resistance quotient
   always_comb begin
      div_req.start   = 1'b0;
      div_req.msb_idx = cvsa_pkg::DIV_IDX_W'(cvsa_pkg::VNUM_W - 1);
      div_num         = cvsa_pkg::DIV_NUM_W'(vnum_c);
      div_den         = cvsa_pkg::DIV_DEN_W'(half_ff);
      if (state_ff == ST_VDIV) begin
         div_req.start = 1'b1;
      end
      if ((state_ff == ST_RDIV) || (state_ff == ST_RWAIT)) begin
         div_req.start   = (state_ff == ST_RDIV);
         div_req.msb_idx = cvsa_pkg::DIV_IDX_W'(cvsa_pkg::DIV_NUM_W - 1);
         div_num         = rnum_c;
         div_den         = cvsa_pkg::DIV_DEN_W'({scs_ff, {cvsa_pkg::SCALE_SHIFT{1'b0}}});
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      start_mv_in  = start_mv_ff;
      peak_mv_in   = peak_mv_ff;
      steps_in     = steps_ff;
      index_in     = index_ff;
      peak_in      = peak_ff;
      svc_in       = svc_ff;
      scs_in       = scs_ff;
      cur_in       = cur_ff;
      abs_in       = abs_ff;
      k_in         = k_ff;
      half_in      = half_ff;
      dneg_in      = dneg_ff;
      v_in         = v_ff;
      pneg_in      = pneg_ff;
      rneg_in      = rneg_ff;
      mag_in       = mag_ff;
      lo_in        = lo_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_volt_in  = rsp_volt_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_res_in   = rsp_res_ff;

      if (csr_we) begin
         case (csr_index)
            cvsa_pkg::CSR_START_MV:   start_mv_in = csr_wdata;
            cvsa_pkg::CSR_PEAK_MV:    peak_mv_in  = csr_wdata;
            cvsa_pkg::CSR_STEP_COUNT: steps_in    = csr_wdata[cvsa_pkg::STEP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.cmd == cvsa_pkg::CMD_CLEAR) begin
                  index_in = '0;
                  peak_in  = '0;
                  svc_in   = '0;
                  scs_in   = '0;
               end else begin
                  cur_in   = req_bus.current_na;
                  abs_in   = req_bus.current_na[CB-1] ? (CB'(0) - req_bus.current_na)
                                                      : req_bus.current_na;
                  k_in     = k_c;
                  half_in  = half_c;
                  dneg_in  = diff_c[cvsa_pkg::DIFF_W-1];
                  state_in = ST_VMUL;
               end
            end
         end
         ST_VMUL: state_in = ST_VDIV;
         ST_VDIV: state_in = ST_VWAIT;
         ST_VWAIT: begin
            if (div_status.done) begin
               v_in     = vsum_c[VW-1:0];
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            pneg_in  = v_ff[VW-1] ^ cur_ff[CB-1];
            state_in = ST_SMUL;
         end
         ST_SMUL: begin
            // clamp to +-(2^63-1)
            if ($signed(svc_sum_c) > $signed(SVC_MAX)) begin
               svc_in = SVC_MAX[SW-1:0];
            end else if ($signed(svc_sum_c) < $signed(SVC_MIN)) begin
               svc_in = SVC_MIN[SW-1:0];
            end else begin
               svc_in = svc_sum_c[SW-1:0];
            end
            if (abs_ff > peak_ff) begin
               peak_in = abs_ff;
            end
            state_in = ST_SACC;
         end
         ST_SACC: begin
            scs_in   = scs_sum_c[SW] ? {SW{1'b1}} : scs_sum_c[SW-1:0];
            state_in = ST_RMAG;
         end
         ST_RMAG: begin
            if (scs_ff == '0) begin
               res_in   = '0;
               state_in = ST_FIN;
            end else begin
               rneg_in  = svc_ff[SW-1];
               mag_in   = svc_ff[SW-1] ? cvsa_pkg::MAG_W'(SW'(0) - svc_ff)
                                       : svc_ff[cvsa_pkg::MAG_W-1:0];
               state_in = ST_MLO;
            end
         end
         ST_MLO: state_in = ST_MHI;
         ST_MHI: begin
            lo_in    = mul_ff[cvsa_pkg::LO_W-1:0];
            state_in = ST_RDIV;
         end
         ST_RDIV: state_in = ST_RWAIT;
         ST_RWAIT: begin
            if (div_status.done) begin
               res_in   = rneg_ff ? (cvsa_pkg::RES_W'(0) - rmag_c) : rmag_c;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = cvsa_pkg::SAMPLE_INDEX_W'(index_ff);
               rsp_volt_in  = v_ff;
               rsp_cur_in   = cur_ff;
               rsp_peak_in  = peak_ff;
               rsp_res_in   = res_ff;
               if (index_ff != {IB{1'b1}}) begin
                  index_in = index_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_mv_ff  <= cvsa_pkg::START_MV_RESET;
         peak_mv_ff   <= cvsa_pkg::PEAK_MV_RESET;
         steps_ff     <= cvsa_pkg::STEP_COUNT_RESET;
         index_ff     <= '0;
         peak_ff      <= '0;
         svc_ff       <= '0;
         scs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_mv_ff  <= start_mv_in;
         peak_mv_ff   <= peak_mv_in;
         steps_ff     <= steps_in;
         index_ff     <= index_in;
         peak_ff      <= peak_in;
         svc_ff       <= svc_in;
         scs_ff       <= scs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      abs_ff       <= abs_in;
      k_ff         <= k_in;
      half_ff      <= half_in;
      dneg_ff      <= dneg_in;
      mul_ff       <= mul_in;
      v_ff         <= v_in;
      pneg_ff      <= pneg_in;
      rneg_ff      <= rneg_in;
      mag_ff       <= mag_in;
      lo_ff        <= lo_in;
      res_ff       <= res_in;
      rsp_index_ff <= rsp_index_in;
      rsp_volt_ff  <= rsp_volt_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_res_ff   <= rsp_res_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.sample_index    = rsp_index_ff;
   assign rsp_bus.voltage_q       = rsp_volt_ff;
   assign rsp_bus.current_echo    = rsp_cur_ff;
   assign rsp_bus.peak_current_na = rsp_peak_ff;
   assign rsp_bus.resistance_ohm  = rsp_res_ff;

endmodule
